[rtl/atd_pkg.sv]
// Package for the accelerometer tap detector.
// Register indexes, field widths and reset values of the settings registers.
// No dependencies.
`timescale 1ns / 1ps

package atd_pkg;

   localparam int unsigned SampleWidth = 8;
   localparam int unsigned HalfWidth   = SampleWidth - 1;
   localparam int unsigned TickWidth   = 8;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned ThrWidth    = 7;
   localparam int unsigned WinWidth    = 8;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 8;

   typedef logic [CsrIdxWidth-1:0] csr_index_type;

   localparam csr_index_type CSR_JUMP_THRESHOLD = 2'd0;
   localparam csr_index_type CSR_WINDOW_LENGTH  = 2'd1;
   localparam csr_index_type CSR_TAP_SPAN       = 2'd2;

   localparam logic [ThrWidth-1:0] JUMP_THRESHOLD_RST = 7'd20;
   localparam logic [WinWidth-1:0] WINDOW_LENGTH_RST  = 8'd45;
   localparam logic [WinWidth-1:0] TAP_SPAN_RST       = 8'd5;

endpackage

[rtl/accel_tap_detector_unit.sv]
// Top level of the accelerometer tap detector.
// Depends on atd_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

// Takes one sample per clock cycle while the result is not stalled and returns one result per sample, in order.
// A sample goes through an input register and then lands in the result register
// when the result stage advances. The detector state (previous halved sample,
// window counter, tap count, min/max) is updated in the same cycle that the
// result register loads, so samples can follow back to back. A stalled result
// holds the pipe; the input register still takes one more sample while the
// result waits. Settings registers take effect on the next sample that
// reaches the result stage and should be written only while the block is idle.
module accel_tap_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // settings write port
   input  logic                                  csr_write_en,
   input  atd_pkg::csr_index_type                csr_index,
   input  logic [atd_pkg::CsrDataWidth-1:0]      csr_wdata,
   // sample input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [atd_pkg::SampleWidth-1:0] req_z_sample,
   input  logic [atd_pkg::TickWidth-1:0]         req_tick_time,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [atd_pkg::CountWidth-1:0]        rsp_tap_count,
   output logic [atd_pkg::TickWidth-1:0]         rsp_tap_stamp,
   output logic signed [atd_pkg::SampleWidth-1:0] rsp_low_diff,
   output logic signed [atd_pkg::SampleWidth-1:0] rsp_high_diff,
   output logic                                  rsp_tap_now,
   output logic                                  rsp_in_window
);

   localparam int unsigned SW = atd_pkg::SampleWidth;
   localparam int unsigned HW = atd_pkg::HalfWidth;
   localparam int unsigned WW = atd_pkg::WinWidth;

   // settings registers
   logic [atd_pkg::ThrWidth-1:0] thr_ff;
   logic [WW-1:0]                wlen_ff;
   logic [WW-1:0]                span_ff;

   // input stage
   logic                         s1_valid_ff, s1_valid_in;
   logic signed [SW-1:0]         s1_sample_ff;
   logic [atd_pkg::TickWidth-1:0] s1_tick_ff;

   // detector state, also the result payload
   logic signed [HW-1:0]         prev_half_ff, prev_half_in;
   logic [WW-1:0]                win_left_ff, win_left_in;
   logic                         first_up_ff, first_up_in;
   logic [atd_pkg::CountWidth-1:0] taps_ff, taps_in;
   logic signed [SW-1:0]         min_ff, min_in;
   logic signed [SW-1:0]         max_ff, max_in;
   logic [atd_pkg::TickWidth-1:0] stamp_ff, stamp_in;
   logic                         tap_now_ff, tap_now_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         s1_advance;
   logic                         load_out;

   logic signed [HW-1:0]         half;
   logic signed [SW-1:0]         diff;
   logic signed [SW-1:0]         pos_thr, neg_thr;
   logic                         up, down;
   logic [WW-1:0]                limit;
   logic                         opening, tap, track;
   logic [WW-1:0]                win_mid;
   logic signed [SW-1:0]         base_min, base_max;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign load_out   = s1_valid_ff && s1_advance;
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   // sample difference and jump detection
   always_comb begin
      half    = s1_sample_ff[SW-1:1];
      diff    = SW'({half[HW-1], half}) - SW'({prev_half_ff[HW-1], prev_half_ff});
      pos_thr = $signed({1'b0, thr_ff});
      neg_thr = SW'(-pos_thr);
      up      = diff > pos_thr;
      down    = diff < neg_thr;
      limit   = (wlen_ff >= span_ff) ? WW'(wlen_ff - span_ff) : '0;
   end

   // window control and min/max tracking
   always_comb begin
      prev_half_in = prev_half_ff;
      win_left_in  = win_left_ff;
      first_up_in  = first_up_ff;
      taps_in      = taps_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      stamp_in     = stamp_ff;
      tap_now_in   = tap_now_ff;

      opening  = (win_left_ff == '0) && (up || down);
      tap      = (win_left_ff != '0) && (win_left_ff > limit)
                 && ((up && !first_up_ff) || (down && first_up_ff));
      track    = opening || (win_left_ff != '0);
      win_mid  = tap ? limit : win_left_ff;
      base_min = opening ? '0 : min_ff;
      base_max = opening ? '0 : max_ff;

      if (load_out) begin
         prev_half_in = half;
         tap_now_in   = tap;
         if (opening) begin
            first_up_in = up;
            win_left_in = wlen_ff;
         end else if (win_left_ff != '0) begin
            // countdown saturates, a tap with zero remainder closes the window
            win_left_in = (win_mid != '0) ? WW'(win_mid - 1'b1) : '0;
         end
         if (tap) begin
            taps_in  = taps_ff + 1'b1;
            stamp_in = s1_tick_ff;
         end
         if (track) begin
            min_in = (diff < base_min) ? diff : base_min;
            max_in = (diff > base_max) ? diff : base_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= atd_pkg::JUMP_THRESHOLD_RST;
         wlen_ff      <= atd_pkg::WINDOW_LENGTH_RST;
         span_ff      <= atd_pkg::TAP_SPAN_RST;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_half_ff <= '0;
         win_left_ff  <= '0;
         first_up_ff  <= 1'b0;
         taps_ff      <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         stamp_ff     <= '0;
         tap_now_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               atd_pkg::CSR_JUMP_THRESHOLD: thr_ff  <= csr_wdata[atd_pkg::ThrWidth-1:0];
               atd_pkg::CSR_WINDOW_LENGTH:  wlen_ff <= csr_wdata[WW-1:0];
               atd_pkg::CSR_TAP_SPAN:       span_ff <= csr_wdata[WW-1:0];
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_half_ff <= prev_half_in;
         win_left_ff  <= win_left_in;
         first_up_ff  <= first_up_in;
         taps_ff      <= taps_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         stamp_ff     <= stamp_in;
         tap_now_ff   <= tap_now_in;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_sample_ff <= req_z_sample;
         s1_tick_ff   <= req_tick_time;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tap_count = taps_ff;
   assign rsp_tap_stamp = stamp_ff;
   assign rsp_low_diff  = min_ff;
   assign rsp_high_diff = max_ff;
   assign rsp_tap_now   = tap_now_ff;
   assign rsp_in_window = (win_left_ff != '0);

`ifndef ASSERT_OFF
   // a recognized tap bumps the count by exactly one
   a_tap_counts: assert property (@(posedge clock) disable iff (reset)
      load_out && tap |=> taps_ff == $past(taps_ff) + 1'b1)
      else $error("tap count did not advance on a tap");

   // without a tap the count holds
   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !(load_out && tap) |=> taps_ff == $past(taps_ff))
      else $error("tap count changed without a tap");

   // a tap only occurs inside an open window
   a_tap_in_window: assert property (@(posedge clock) disable iff (reset)
      tap |-> win_left_ff != '0)
      else $error("tap outside window");

   // a stalled input stage keeps its transaction
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_sample_ff)
      && $stable(s1_tick_ff))
      else $error("input stage lost a stalled transaction");
`endif

endmodule
